[design/sbit_pkg.sv]
// ----------------------------------------------------------------------------
// sbit_pkg
// Shared types, constants and sizing helpers for the breakpoint interval table.
// ----------------------------------------------------------------------------
package sbit_pkg;

    localparam int CAPACITY    = 1024;
    localparam int POINT_W     = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_CNT_W = 11;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int PAIR_W      = 2 * POINT_W;
    localparam int TREE_RADIX  = 32;

    // Entries are kept with the sign bit flipped so unsigned order is signed order.
    localparam logic [POINT_W-1:0] BIAS      = {1'b1, {(POINT_W-1){1'b0}}};
    localparam logic [POINT_W-1:0] LOW_SENT  = '0;
    localparam logic [POINT_W-1:0] HIGH_SENT = '1;

    // Nodes left after a given number of reduction levels.
    function automatic int tree_nodes(int level);
        int n;
        n = CAPACITY;
        for (int s = 0; s < level; s++) begin
            n = (n + TREE_RADIX - 1) / TREE_RADIX;
        end
        return n;
    endfunction

    function automatic int tree_levels();
        int n;
        int l;
        n = CAPACITY;
        l = 0;
        while (n > 1) begin
            n = (n + TREE_RADIX - 1) / TREE_RADIX;
            l++;
        end
        return l;
    endfunction

    localparam int TREE_STAGES = tree_levels();
    localparam int SCAN_CNT_W  = (TREE_STAGES > 1) ? $clog2(TREE_STAGES) : 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_e;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_PRESENT  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_SENTINEL = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_e;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [POINT_W-1:0] point;
    } req_t;

    typedef struct packed {
        status_e                   status;
        logic signed [POINT_W-1:0] lower_bound;
        logic signed [POINT_W-1:0] upper_bound;
        logic [ENTRY_CNT_W-1:0]    entry_count;
    } rsp_t;

    typedef struct packed {
        logic insert;
        logic clear;
    } cell_ctl_t;

endpackage

[design/sbit_cell.sv]
// ----------------------------------------------------------------------------
// sbit_cell
// One table slot: holds an entry and its in-use bit, compares against the
// key and takes its neighbor's entry when an insert shifts the table up.
// ----------------------------------------------------------------------------
module sbit_cell
    import sbit_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [POINT_W-1:0] key,
    input  logic [POINT_W-1:0] init_val,
    input  logic               init_occ,
    input  logic [POINT_W-1:0] prev_val,
    input  logic               prev_mv,
    input  logic               prev_occ,
    input  logic [POINT_W-1:0] next_val,
    input  logic               next_occ,
    input  logic               next_lv,
    output logic [POINT_W-1:0] val,
    output logic               occ,
    output logic               lv,
    output logic               mv,
    output logic [PAIR_W-1:0]  leaf
);

    logic [POINT_W-1:0] val_reg;
    logic [POINT_W-1:0] val_next;
    logic               occ_reg;
    logic               occ_next;

    // lv: slot is a lower-bound candidate (not the top sentinel, not above key)
    assign lv   = next_occ && (val_reg <= key);
    assign mv   = !lv;
    assign leaf = (lv && !next_lv) ? {val_reg, next_val} : '0;
    assign val  = val_reg;
    assign occ  = occ_reg;

    // Clear wins over insert; with neither the slot holds.
    always_comb
    begin
        val_next = val_reg;
        occ_next = occ_reg;
        if (ctl.clear)
        begin
            val_next = init_val;
            occ_next = init_occ;
        end
        else if (ctl.insert)
        begin
            val_next = prev_mv ? prev_val : (mv ? key : val_reg);
            occ_next = prev_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= init_val;
            occ_reg <= init_occ;
        end
        else
        begin
            val_reg <= val_next;
            occ_reg <= occ_next;
        end
    end

endmodule

[design/sbit_or_tree.sv]
// ----------------------------------------------------------------------------
// sbit_or_tree
// Registered OR reduction of the one-hot cell outputs, TREE_RADIX to a level.
// ----------------------------------------------------------------------------
module sbit_or_tree
    import sbit_pkg::*;
(
    input  logic              clk,
    input  logic [PAIR_W-1:0] leaf [CAPACITY],
    output logic [PAIR_W-1:0] pair
);

    logic [PAIR_W-1:0] lvl_reg [TREE_STAGES][CAPACITY];

    for (genvar s = 0; s < TREE_STAGES; s++)
    begin : g_lvl
        localparam int NI = tree_nodes(s);
        localparam int NO = tree_nodes(s + 1);

        for (genvar k = 0; k < CAPACITY; k++)
        begin : g_node
            logic [PAIR_W-1:0] acc;

            if (s == 0)
            begin : g_first
                always_comb
                begin
                    acc = '0;
                    if (k < NO)
                    begin
                        for (int j = 0; j < TREE_RADIX; j++)
                        begin
                            if (k * TREE_RADIX + j < NI)
                            begin
                                acc = acc | leaf[k * TREE_RADIX + j];
                            end
                        end
                    end
                end
            end
            else
            begin : g_upper
                always_comb
                begin
                    acc = '0;
                    if (k < NO)
                    begin
                        for (int j = 0; j < TREE_RADIX; j++)
                        begin
                            if (k * TREE_RADIX + j < NI)
                            begin
                                acc = acc | lvl_reg[s-1][k * TREE_RADIX + j];
                            end
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                lvl_reg[s][k] <= acc;
            end
        end
    end

    assign pair = lvl_reg[TREE_STAGES-1][0];

endmodule

[design/sorted_breakpoint_interval_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_breakpoint_interval_table_top
// Sorted table of signed breakpoints between two sentinels: insert, interval
// query and clear, one request at a time over a row of compare/shift cells.
// ----------------------------------------------------------------------------
// Timing: done is registered from the COMMIT state, which follows SCAN;
//   the SCAN stay is set by the registered OR tree depth.
// Requests: one at a time, none taken until the commit ends; busy is high from the
//   accepting edge until the commit cycle ends.
// Reset: table holds only the two sentinels, entry count 2, ready at once.
// The result receiver cannot stall; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module sorted_breakpoint_interval_table_top
    import sbit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    // ------------------------------------------------------------------------
    // Control and request registers
    // ------------------------------------------------------------------------
    state_e                 state_reg;
    state_e                 state_next;
    logic [SCAN_CNT_W-1:0]  scan_cnt_reg;
    logic [SCAN_CNT_W-1:0]  scan_cnt_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   done_reg;
    rsp_t                   result_reg;
    rsp_t                   result_next;
    logic [POINT_W-1:0]     key_reg;     // biased key
    logic [FUNC_W-1:0]      func_reg;

    logic                   accept;
    cell_ctl_t              cell_ctl;

    // ------------------------------------------------------------------------
    // Cell row: every cell compares its entry with the key in parallel.
    // Cell j is the lower bound when it is a candidate and cell j+1 is not;
    // on insert, the first cell above the lower bound takes the key, and every
    // cell above that one takes its lower neighbor's entry.
    // ------------------------------------------------------------------------
    logic [POINT_W-1:0]  cell_val  [CAPACITY];
    logic [PAIR_W-1:0]   cell_leaf [CAPACITY];
    logic [CAPACITY-1:0] cell_occ;
    logic [CAPACITY-1:0] cell_lv;
    logic [CAPACITY-1:0] cell_mv;

    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        sbit_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .key      (key_reg),
            .init_val ((j == 0) ? LOW_SENT : HIGH_SENT),
            .init_occ ((j < 2) ? 1'b1 : 1'b0),
            .prev_val (cell_val[(j == 0) ? 0 : j - 1]),
            .prev_mv  ((j == 0) ? 1'b0 : cell_mv[(j == 0) ? 0 : j - 1]),
            .prev_occ ((j == 0) ? 1'b1 : cell_occ[(j == 0) ? 0 : j - 1]),
            .next_val (cell_val[(j == CAPACITY - 1) ? j : j + 1]),
            .next_occ ((j == CAPACITY - 1) ? 1'b0 :
                       cell_occ[(j == CAPACITY - 1) ? j : j + 1]),
            .next_lv  ((j == CAPACITY - 1) ? 1'b0 :
                       cell_lv[(j == CAPACITY - 1) ? j : j + 1]),
            .val      (cell_val[j]),
            .occ      (cell_occ[j]),
            .lv       (cell_lv[j]),
            .mv       (cell_mv[j]),
            .leaf     (cell_leaf[j])
        );
    end

    // Exactly one cell is the lower bound, so an OR tree picks out its pair.
    logic [PAIR_W-1:0]  bound_pair;
    logic [POINT_W-1:0] lower_b;
    logic [POINT_W-1:0] upper_b;

    sbit_or_tree u_tree (
        .clk  (clk),
        .leaf (cell_leaf),
        .pair (bound_pair)
    );

    assign lower_b = bound_pair[PAIR_W-1:POINT_W];
    assign upper_b = bound_pair[POINT_W-1:0];

    // ------------------------------------------------------------------------
    // Sequencer: IDLE -> SCAN (tree fills) -> COMMIT (decide, update, report)
    // ------------------------------------------------------------------------
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = SCAN_CNT_W'(TREE_STAGES - 1);
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == '0)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commit decisions: sentinel check, duplicate check, then capacity.
    // Query and the unused code leave the table alone.
    always_comb
    begin
        cell_ctl    = '0;
        count_next  = count_reg;
        result_next = result_reg;
        busy        = (state_reg != ST_IDLE);
        if (state_reg == ST_COMMIT)
        begin
            result_next.status      = STAT_DONE;
            result_next.lower_bound = $signed(lower_b ^ BIAS);
            result_next.upper_bound = $signed(upper_b ^ BIAS);
            if (func_reg == FUNC_INSERT)
            begin
                priority if (key_reg == LOW_SENT || key_reg == HIGH_SENT)
                begin
                    result_next.status = STAT_SENTINEL;
                end
                else if (lower_b == key_reg)
                begin
                    result_next.status = STAT_PRESENT;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    result_next.status = STAT_FULL;
                end
                else
                begin
                    cell_ctl.insert = 1'b1;
                    count_next      = count_reg + 1'b1;
                end
            end
            else if (func_reg == FUNC_CLEAR)
            begin
                cell_ctl.clear = 1'b1;
                count_next     = CNT_W'(2);
            end
            result_next.entry_count = ENTRY_CNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= CNT_W'(2);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            done_reg     <= (state_reg == ST_COMMIT);
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= POINT_W'(request.point) ^ BIAS;
            func_reg <= request.func;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_sentinel_slots: assert property (@(posedge clk) disable iff (!rst_n)
        cell_occ[1:0] == 2'b11)
        else $error("sentinel slots not in use");

    a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_occ) == int'(count_reg))
        else $error("entry count disagrees with cell occupancy");

    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_COMMIT))
        else $error("result strobe without commit");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == STAT_FULL |-> count_reg == CNT_W'(CAPACITY))
        else $error("table full reported below capacity");

    for (genvar j = 0; j < CAPACITY - 1; j++)
    begin : g_chk
        a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            cell_occ[j+1] |-> cell_val[j] < cell_val[j+1])
            else $error("table entries out of order");
    end

endmodule
